### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/drld_pkg.sv
// ----------------------------------------------------------------------------
// drld_pkg
// Shared types and constants for the data run list decoder.
// ----------------------------------------------------------------------------
package drld_pkg;

  localparam int unsigned LenW   = 32;
  localparam int unsigned OffW   = 64;
  localparam int unsigned TotalW = 63;

  // Largest legal field sizes in a header byte.
  localparam logic [3:0] MaxLenBytes = 4'd4;
  localparam logic [3:0] MaxOffBytes = 4'd8;

  typedef struct packed {
    logic [LenW-1:0]          run_length;
    logic signed [OffW-1:0]   relative_offset;
    logic signed [OffW-1:0]   start_cluster;
    logic [TotalW-1:0]        cluster_total;
    logic                     sparse;
    logic                     list_end;
    logic                     malformed;
  } drld_result_t;

endpackage

### hw/rtl/drld_core.sv
// ----------------------------------------------------------------------------
// drld_core
// Run list byte parser: header, length and offset phases, cluster tracking.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module drld_core
  import drld_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic [7:0]   data_byte,
  input  logic         start_of_list,
  output logic         res_valid,
  output drld_result_t res
);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_OFFSET,
    PH_HALTED
  } phase_t;

  phase_t              phase_r, phase_nxt, phase_eff;
  logic [3:0]          cnt_r, cnt_nxt, cnt_inc;
  logic [2:0]          len_bytes_r, len_bytes_nxt;
  logic [3:0]          off_bytes_r, off_bytes_nxt;
  logic [LenW-1:0]     len_acc_r, len_acc_nxt, len_merged, len_fin;
  logic [OffW-1:0]     off_acc_r, off_acc_nxt, off_merged, ext_mask, rel;
  logic [OffW-1:0]     prev_r, prev_nxt, prev_eff, start_sum;
  logic [TotalW-1:0]   total_r, total_nxt, total_eff, total_sum;
  logic [3:0]          hdr_len, hdr_off;
  logic [6:0]          off_bits;

  assign hdr_len = data_byte[3:0];
  assign hdr_off = data_byte[7:4];

  assign phase_eff = start_of_list ? PH_HEADER : phase_r;
  assign prev_eff  = start_of_list ? '0 : prev_r;
  assign total_eff = start_of_list ? '0 : total_r;

  assign cnt_inc    = cnt_r + 4'd1;
  assign len_merged = len_acc_r | ({{(LenW-8){1'b0}}, data_byte} << {cnt_r[1:0], 3'b000});
  assign off_merged = off_acc_r | ({{(OffW-8){1'b0}}, data_byte} << {cnt_r[2:0], 3'b000});

  // Sign-extend from the top received byte; a full 8-byte field needs no extension.
  assign off_bits  = {off_bytes_r, 3'b000};
  assign ext_mask  = ~((64'd1 << off_bits) - 64'd1);
  assign rel       = data_byte[7] ? (off_merged | ext_mask) : off_merged;
  assign start_sum = prev_r + rel;

  assign len_fin   = (phase_r == PH_LENGTH) ? len_merged : len_acc_r;
  assign total_sum = total_r + {{(TotalW-LenW){1'b0}}, len_fin};

  always_comb begin
    phase_nxt     = phase_eff;
    cnt_nxt       = cnt_r;
    len_bytes_nxt = len_bytes_r;
    off_bytes_nxt = off_bytes_r;
    len_acc_nxt   = len_acc_r;
    off_acc_nxt   = off_acc_r;
    prev_nxt      = prev_eff;
    total_nxt     = total_eff;
    res_valid     = 1'b0;
    res           = '0;

    case (phase_eff)
      PH_HEADER: begin
        if (hdr_len == 4'd0) begin
          res_valid         = 1'b1;
          res.list_end      = 1'b1;
          res.cluster_total = total_eff;
          phase_nxt         = PH_HALTED;
        end else if (hdr_len > MaxLenBytes || hdr_off > MaxOffBytes) begin
          res_valid     = 1'b1;
          res.malformed = 1'b1;
          phase_nxt     = PH_HALTED;
        end else begin
          len_bytes_nxt = hdr_len[2:0];
          off_bytes_nxt = hdr_off;
          cnt_nxt       = '0;
          len_acc_nxt   = '0;
          off_acc_nxt   = '0;
          phase_nxt     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        len_acc_nxt = len_merged;
        cnt_nxt     = cnt_inc;
        if (cnt_inc >= {1'b0, len_bytes_r}) begin
          cnt_nxt = '0;
          if (off_bytes_r == 4'd0) begin
            // Sparse run: previous cluster stays put.
            res_valid         = 1'b1;
            res.run_length    = len_merged;
            res.start_cluster = prev_r;
            res.cluster_total = total_sum;
            res.sparse        = 1'b1;
            total_nxt         = total_sum;
            phase_nxt         = PH_HEADER;
          end else begin
            phase_nxt = PH_OFFSET;
          end
        end
      end
      PH_OFFSET: begin
        off_acc_nxt = off_merged;
        cnt_nxt     = cnt_inc;
        if (cnt_inc >= off_bytes_r) begin
          cnt_nxt             = '0;
          res_valid           = 1'b1;
          res.run_length      = len_acc_r;
          res.relative_offset = rel;
          res.start_cluster   = start_sum;
          res.cluster_total   = total_sum;
          prev_nxt            = start_sum;
          total_nxt           = total_sum;
          phase_nxt           = PH_HEADER;
        end
      end
      default: begin
        // Halted: drop bytes until the next start of list.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      cnt_r       <= '0;
      len_bytes_r <= '0;
      off_bytes_r <= '0;
      len_acc_r   <= '0;
      off_acc_r   <= '0;
      prev_r      <= '0;
      total_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      len_bytes_r <= len_bytes_nxt;
      off_bytes_r <= off_bytes_nxt;
      len_acc_r   <= len_acc_nxt;
      off_acc_r   <= off_acc_nxt;
      prev_r      <= prev_nxt;
      total_r     <= total_nxt;
    end
  end

  `ASSERT_NEXT(a_halt_after_end, step && res_valid && (res.list_end || res.malformed),
    phase_r == PH_HALTED, "decoder did not halt after end or malformed header")
  `ASSERT_IMPLY(a_halted_silent, phase_r == PH_HALTED && !start_of_list, !res_valid,
    "result produced while halted")
  `ASSERT_IMPLY(a_one_kind, res_valid, $onehot0({res.sparse, res.list_end, res.malformed}),
    "result flagged as more than one kind")
  `ASSERT_IMPLY(a_len_count_bound, phase_r == PH_LENGTH, cnt_r < {1'b0, len_bytes_r},
    "length byte count ran past field size")

endmodule

### hw/rtl/data_run_list_decoder.sv
// ----------------------------------------------------------------------------
// data_run_list_decoder
// Decodes a run list one byte per transaction into per-run results.
// ----------------------------------------------------------------------------
// The block takes one run-list byte per clock and never stalls its input
// unless a finished result is held in the output register and the consumer
// is stalling. Each byte is parsed in the cycle it is accepted; a run's
// result appears in the output register on the clock after its last byte.
// Throughput is one byte per cycle while the input is not stalled. The path
// that sets the clock rate is the 64-bit start cluster add after the
// offset sign extension. After an end-of-list or malformed header, bytes
// are dropped without results until a byte arrives with start_of_list set.
`include "assert_macros.svh"

module data_run_list_decoder
  import drld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_data_byte,
  input  logic                    in_start_of_list,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LenW-1:0]         out_run_length,
  output logic signed [OffW-1:0]  out_relative_offset,
  output logic signed [OffW-1:0]  out_start_cluster,
  output logic [TotalW-1:0]       out_cluster_total,
  output logic                    out_sparse,
  output logic                    out_list_end,
  output logic                    out_malformed
);

  logic         in_take;
  logic         res_valid;
  drld_result_t res;
  logic         out_valid_r;
  drld_result_t out_r;

  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  drld_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (in_take),
    .data_byte     (in_data_byte),
    .start_of_list (in_start_of_list),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load a new result only when the register is free or draining.
  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_run_length      = out_r.run_length;
  assign out_relative_offset = out_r.relative_offset;
  assign out_start_cluster   = out_r.start_cluster;
  assign out_cluster_total   = out_r.cluster_total;
  assign out_sparse          = out_r.sparse;
  assign out_list_end        = out_r.list_end;
  assign out_malformed       = out_r.malformed;

  `ASSERT_IMPLY(a_stall_needs_result, in_stall, out_valid_r,
    "input stalled with no result held")
  `ASSERT_IMPLY(a_malformed_clear, out_valid_r && out_malformed,
    out_run_length == '0 && out_start_cluster == '0 && out_cluster_total == '0,
    "malformed result carries nonzero fields")
  `ASSERT_IMPLY(a_sparse_rel_zero, out_valid_r && out_sparse, out_relative_offset == '0,
    "sparse run with nonzero relative offset")

endmodule
